// ===== src/ecmc_pkg.sv =====
// ============================================================================
// ecmc_pkg: shared types and constants for the encoder multiturn count core
// Check-bit masks, the classified frame record and the check-bit function.
// ============================================================================
package ecmc_pkg;

    localparam int WordWidth   = 16;
    localparam int AngleWidth  = 12;
    localparam int RawTurnBits = 14;
    localparam int TurnsWidth  = 15;
    localparam int TrackWidth  = 20;
    localparam int TotalWidth  = 32;

    // Data bits covered by the odd (bit 15) and even (bit 14) check bits.
    localparam logic [WordWidth-1:0] PosOddMask   = 16'h2AA8;
    localparam logic [WordWidth-1:0] PosEvenMask  = 16'h1554;
    localparam logic [WordWidth-1:0] TurnOddMask  = 16'h2AAA;
    localparam logic [WordWidth-1:0] TurnEvenMask = 16'h1555;

    localparam logic [RawTurnBits-1:0] TurnWrapLimit = 14'd8000;
    localparam logic [15:0]            TurnWrapSpan  = 16'd16384;

    localparam logic signed [TrackWidth-1:0] TrackMax = 20'sh7FFFF;
    localparam logic signed [TrackWidth-1:0] TrackMin = 20'sh80000;

    typedef struct packed {
        logic                         frame_ok;
        logic [AngleWidth-1:0]        angle;
        logic signed [TurnsWidth-1:0] turns;
    } t_frame;

    // Each check bit must equal the inverted XOR of the bits it covers.
    function automatic logic word_ok(input logic [WordWidth-1:0] w,
                                     input logic [WordWidth-1:0] odd_mask,
                                     input logic [WordWidth-1:0] even_mask);
        logic odd_bit;
        logic even_bit;
        odd_bit  = ~^(w & odd_mask);
        even_bit = ~^(w & even_mask);
        return (w[15] == odd_bit) && (w[14] == even_bit);
    endfunction

endpackage

// ===== src/ecmc_front.sv =====
// ============================================================================
// ecmc_front: request intake and frame classification
// Checks both reply words and extracts the angle and wrapped turn value.
// ============================================================================
module ecmc_front (
    input  logic                          i_in_valid,
    input  logic [15:0]                   i_position_word,
    input  logic [15:0]                   i_turns_word,
    input  logic                          i_queue_full,
    output logic                          o_in_stall,
    output logic                          o_push,
    output ecmc_pkg::t_frame              o_frame
);
    import ecmc_pkg::*;

    logic [RawTurnBits-1:0] raw_turns;
    logic [15:0]            wrapped;

    assign raw_turns = i_turns_word[RawTurnBits-1:0];

    always_comb begin
        if (raw_turns > TurnWrapLimit) begin
            wrapped = {2'b00, raw_turns} - TurnWrapSpan + 16'd1;
        end else begin
            wrapped = {2'b00, raw_turns} + 16'd1;
        end
    end

    assign o_frame.frame_ok = word_ok(i_position_word, PosOddMask, PosEvenMask)
                            && word_ok(i_turns_word, TurnOddMask, TurnEvenMask);
    assign o_frame.angle    = i_position_word[13:2];
    assign o_frame.turns    = wrapped[TurnsWidth-1:0];

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

endmodule

// ===== src/ecmc_queue.sv =====
// ============================================================================
// ecmc_queue: two-entry queue of classified frames
// Decouples request intake from the tracking back end.
// ============================================================================
module ecmc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ecmc_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ecmc_pkg::t_frame o_frame
);
    import ecmc_pkg::*;

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_frame = r_mem[r_rd_ptr];

endmodule

// ===== src/ecmc_back.sv =====
// ============================================================================
// ecmc_back: turn tracking and result register
// Updates the accumulated turn count and forms the total count per frame.
// ============================================================================
module ecmc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ecmc_pkg::t_frame i_frame,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_frame_ok,
    output logic [11:0]      o_angle,
    output logic signed [14:0] o_device_turns,
    output logic signed [19:0] o_tracked_turns,
    output logic signed [31:0] o_total_count
);
    import ecmc_pkg::*;

    logic                         r_out_valid;
    logic                         r_frame_ok;
    logic                         r_seen;
    logic signed [TurnsWidth-1:0] r_prev;
    logic signed [TrackWidth-1:0] r_acc;
    logic [AngleWidth-1:0]        r_angle;
    logic signed [TurnsWidth-1:0] r_turns;
    logic signed [TotalWidth-1:0] r_total;

    logic                         n_out_valid;
    logic signed [TrackWidth-1:0] n_acc;
    logic signed [TotalWidth-1:0] n_total;
    logic signed [15:0]           diff;
    logic signed [TrackWidth:0]   acc_sum;
    logic [32:0]                  total_wide;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        diff    = {i_frame.turns[TurnsWidth-1], i_frame.turns}
                - {r_prev[TurnsWidth-1], r_prev};
        acc_sum = {r_acc[TrackWidth-1], r_acc}
                + {{(TrackWidth-15){diff[15]}}, diff};
        n_acc   = r_acc;
        if (r_seen && (diff > -16'sd3) && (diff < 16'sd3)) begin
            if (acc_sum[TrackWidth] != acc_sum[TrackWidth-1]) begin
                n_acc = acc_sum[TrackWidth] ? TrackMin : TrackMax;
            end else begin
                n_acc = acc_sum[TrackWidth-1:0];
            end
        end
        // Multiplying by 4095 is a shift by twelve less one copy.
        total_wide = {n_acc[TrackWidth-1], n_acc, 12'd0}
                   - {{13{n_acc[TrackWidth-1]}}, n_acc}
                   + {21'd0, i_frame.angle};
        n_total    = total_wide[TotalWidth-1:0];
    end

    always_comb begin
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_frame_ok  <= 1'b0;
            r_seen      <= 1'b0;
            r_prev      <= '0;
            r_acc       <= '0;
            r_angle     <= '0;
            r_turns     <= '0;
            r_total     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_frame_ok <= i_frame.frame_ok;
                if (i_frame.frame_ok) begin
                    r_seen  <= 1'b1;
                    r_prev  <= i_frame.turns;
                    r_acc   <= n_acc;
                    r_angle <= i_frame.angle;
                    r_turns <= i_frame.turns;
                    r_total <= n_total;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_ok      = r_frame_ok;
    assign o_angle         = r_angle;
    assign o_device_turns  = r_turns;
    assign o_tracked_turns = r_acc;
    assign o_total_count   = r_total;

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_frame.frame_ok) |=> ($stable(r_acc) && $stable(r_total)))
        else $error("failed frame changed the held count");

    a_first_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_frame.frame_ok && !r_seen) |=> (r_seen && $stable(r_acc)))
        else $error("first valid frame changed the accumulated turns");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped frame did not reach the result register");

    a_no_seen_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_acc == '0))
        else $error("turns accumulated before the first valid frame");

endmodule

// ===== src/encoder_checkbit_multiturn_count_core.sv =====
// ============================================================================
// encoder_checkbit_multiturn_count_core: absolute encoder multiturn counter
// Checks encoder reply words and tracks a saturating multiturn count.
// ============================================================================
// Each request carries the raw position and turns reply words of an absolute
// encoder and yields exactly one result. A frame whose check bits fail gives
// frame_ok low and repeats the last good values. Requests are taken one per
// clock while input stall is low: the front checks the words and writes a
// two-entry queue, and the back updates the turn tracking and loads the
// result register, so a request's result passes through the queue and then
// the result register. Input stall rises only while the queue is full.
module encoder_checkbit_multiturn_count_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_position_word,
    input  logic [15:0]        i_turns_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_frame_ok,
    output logic [11:0]        o_angle,
    output logic signed [14:0] o_device_turns,
    output logic signed [19:0] o_tracked_turns,
    output logic signed [31:0] o_total_count
);
    import ecmc_pkg::*;

    t_frame front_frame;
    t_frame head_frame;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_valid;

    ecmc_front u_front (
        .i_in_valid      (i_in_valid),
        .i_position_word (i_position_word),
        .i_turns_word    (i_turns_word),
        .i_queue_full    (queue_full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_frame         (front_frame)
    );

    ecmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_frame (head_frame)
    );

    ecmc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (queue_valid),
        .i_frame         (head_frame),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_frame_ok      (o_frame_ok),
        .o_angle         (o_angle),
        .o_device_turns  (o_device_turns),
        .o_tracked_turns (o_tracked_turns),
        .o_total_count   (o_total_count)
    );

endmodule
